FILE: hw/rtl/tlbe_pkg.sv
// Package for the line parser with binary escape blocks.
// Holds the parse modes, action codes, byte constants and the result record.
// No dependencies.
package tlbe_pkg;

	// Parse modes; the code left over is handled as text mode
	typedef enum logic [1:0] {
		MODE_TEXT = 2'd0,
		MODE_BIN  = 2'd1,
		MODE_EOL  = 2'd2
	} mode_t;

	// Verdict for one byte
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_LINE   = 2'd1,
		ACT_SKIP   = 2'd2
	} action_t;

	localparam logic [7:0] ESCAPE_BYTE = 8'h7C;
	localparam logic [7:0] LF_BYTE     = 8'h0A;
	localparam logic [7:0] CR_BYTE     = 8'h0D;

	// Number of big-endian length bytes after the escape
	localparam logic [32:0] LEN_BYTES = 33'd4;

	// Configuration register map
	localparam int unsigned PADDR_W = 3;
	localparam logic [0:0] REG_CR_EOL = 1'b0;

	// One result record
	typedef struct packed {
		logic [7:0] out_byte;
		action_t    action;
		logic       in_binary_block;
	} result_t;

endpackage

FILE: hw/rtl/tlbe_ifs.sv
// Valid/ready channel interfaces for the line parser.
// No package dependency; the action is carried as a plain two-bit field.
interface tlbe_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tlbe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] action;
	logic       in_binary_block;

	modport source (output valid, output out_byte, output action, output in_binary_block,
		input ready);
	modport sink (input valid, input out_byte, input action, input in_binary_block,
		output ready);
endinterface

FILE: hw/rtl/tlbe_cfg.sv
// APB-style configuration register for the line parser.
// Holds the carriage-return-as-end-of-line bit. Depends on tlbe_pkg.
module tlbe_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tlbe_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic                        cr_eol
);
	import tlbe_pkg::*;

	logic cr_eol_q;
	logic wr_en;
	logic sel_cr;

	// Register index is paddr[2]; the low address bits are don't care
	assign sel_cr = (paddr[2] == REG_CR_EOL);
	assign wr_en  = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_eol_q <= 1'b1;
		end else if (wr_en && sel_cr) begin
			cr_eol_q <= pwdata[0];
		end
	end

	// Read back
	assign prdata = sel_cr ? {31'd0, cr_eol_q} : 32'd0;
	assign cr_eol = cr_eol_q;

endmodule

FILE: hw/rtl/tlbe_core.sv
// Parser datapath: input register, mode logic and result register.
// Depends on tlbe_pkg.
module tlbe_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cr_eol,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              in_byte,
	output logic                    out_valid,
	input  logic                    out_ready,
	output tlbe_pkg::result_t       out_res
);
	import tlbe_pkg::*;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	// Result stage
	logic       valid_s2;
	result_t    res_s2;

	// Parser state
	mode_t       mode_q, mode_d;
	logic [31:0] len_q, len_d;
	logic [32:0] pos_q, pos_d;

	logic        adv;
	logic        is_eol;
	logic [32:0] pos_inc;
	logic [31:0] len_shift;
	action_t     act;
	logic        bin;

	// Handshake: s1 moves into s2 when s2 is empty or being drained
	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign is_eol    = (byte_s1 == LF_BYTE) || (cr_eol && (byte_s1 == CR_BYTE));
	assign pos_inc   = pos_q + 33'd1;
	assign len_shift = {len_q[23:0], byte_s1};

	// Next state
	always_comb begin
		mode_d = mode_q;
		len_d  = len_q;
		pos_d  = pos_q;
		unique case (mode_q)
			MODE_BIN: begin
				pos_d = pos_inc;
				if (pos_q[32:2] == 31'd0) begin
					len_d = len_shift;
					if (pos_inc == LEN_BYTES && len_shift == 32'd0) begin
						mode_d = MODE_TEXT;
					end
				end else if (pos_inc == ({1'b0, len_q} + LEN_BYTES)) begin
					mode_d = MODE_TEXT;
				end
			end
			MODE_EOL: begin
				if (is_eol) begin
					mode_d = MODE_EOL;
				end else if (byte_s1 == ESCAPE_BYTE) begin
					mode_d = MODE_BIN;
					len_d  = 32'd0;
					pos_d  = 33'd0;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
			default: begin
				// text mode, and the unused code
				if (byte_s1 == ESCAPE_BYTE) begin
					mode_d = MODE_BIN;
					len_d  = 32'd0;
					pos_d  = 33'd0;
				end else if (is_eol) begin
					mode_d = MODE_EOL;
				end else begin
					mode_d = MODE_TEXT;
				end
			end
		endcase
	end

	// Outputs
	always_comb begin
		act = ACT_APPEND;
		bin = 1'b0;
		unique case (mode_q)
			MODE_BIN: begin
				bin = 1'b1;
			end
			MODE_EOL: begin
				if (is_eol) begin
					act = ACT_SKIP;
				end else if (byte_s1 == ESCAPE_BYTE) begin
					bin = 1'b1;
				end
			end
			default: begin
				if (byte_s1 == ESCAPE_BYTE) begin
					bin = 1'b1;
				end else if (is_eol) begin
					act = ACT_LINE;
				end
			end
		endcase
	end

	// State advances once per byte, as it leaves s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
			len_q  <= 32'd0;
			pos_q  <= 33'd0;
		end else if (adv) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			pos_q  <= pos_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.out_byte        <= byte_s1;
			res_s2.action          <= act;
			res_s2.in_binary_block <= bin;
		end
	end

	assign out_valid = valid_s2;
	assign out_res   = res_s2;

endmodule

FILE: hw/rtl/text_line_binary_escape_parser.sv
// Line parser with binary escape blocks: one byte in, one verdict out.
// Channels: din (sink) takes one byte per request; dout (source) gives the
// byte back with its action (append, line complete, skip extra end-of-line)
// and a flag that marks bytes of a binary block ('|', four big-endian length
// bytes, then the payload). A request moves on valid && ready.
// Configuration: APB-style port, register 0 bit 0 = carriage return also
// ends a line (reset 1). Write only while the parser is idle.
// Path: an accepted byte passes the input register, then the result register,
// before it is offered on dout.
// Throughput: one byte per cycle unless dout stalls; mode update is a single
// pass of compare and 33-bit add/compare logic between the two registers.
// Stall: when dout is held, the result register and then the input register
// fill and din.ready drops; nothing is lost or repeated.
// Reset: arst_n, asynchronous active low, clears both stages and puts the
// parser in text mode with zero block length and position.
// Depends on tlbe_pkg, tlbe_ifs, tlbe_cfg and tlbe_core.
module text_line_binary_escape_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tlbe_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	tlbe_in_if.sink                      din,
	tlbe_out_if.source                   dout
);
	import tlbe_pkg::*;

	logic    cr_eol;
	result_t res;

	tlbe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cr_eol  (cr_eol)
	);

	tlbe_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cr_eol    (cr_eol),
		.in_valid  (din.valid),
		.in_ready  (din.ready),
		.in_byte   (din.in_byte),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.out_res   (res)
	);

	assign dout.out_byte        = res.out_byte;
	assign dout.action          = res.action;
	assign dout.in_binary_block = res.in_binary_block;

endmodule

FILE: test/tlbe_line_checker.sv
// Passive checker for the line parser: watches both byte channels and the
// register port, predicts each verdict and compares it in order.
// Depends on tlbe_pkg and the channel interfaces in tlbe_ifs.
`timescale 1ns / 100ps

module tlbe_line_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic                         pready,
	input  logic [tlbe_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	tlbe_in_if                           din,
	tlbe_out_if                          dout,
	output int unsigned                  mismatches,
	output int unsigned                  pending
);
	import tlbe_pkg::*;

	localparam logic [PADDR_W-1:0] CR_EOL_ADDR = PADDR_W'(4 * REG_CR_EOL);
	localparam int unsigned        REPORT_CAP  = 60;

	// Shadow of the parser state and its one register
	logic        cr_ends_line;
	mode_t       mode;
	logic [31:0] blk_len;
	logic [32:0] blk_pos;

	result_t     verdict_q[$];
	int unsigned results_seen;

	initial mismatches = 0;

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_CAP) begin
			$display("%0t ns: %s", $time, msg);
		end
		mismatches++;
	endtask

	// Verdict for one byte; advances the shadow state
	function automatic result_t classify_byte(input logic [7:0] b);
		result_t r;
		logic    eol;
		r.out_byte        = b;
		r.action          = ACT_APPEND;
		r.in_binary_block = 1'b0;
		eol = (b == LF_BYTE) || (cr_ends_line && b == CR_BYTE);
		case (mode)
		MODE_BIN: begin
			r.in_binary_block = 1'b1;
			if (blk_pos < LEN_BYTES) begin
				// big-endian length bytes; an empty block ends on the last one
				blk_len = {blk_len[23:0], b};
				blk_pos = blk_pos + 33'd1;
				if (blk_pos == LEN_BYTES && blk_len == 32'd0) begin
					mode = MODE_TEXT;
				end
			end else begin
				blk_pos = blk_pos + 33'd1;
				if (blk_pos == LEN_BYTES + {1'b0, blk_len}) begin
					mode = MODE_TEXT;
				end
			end
		end
		// text, after end-of-line, and the unused code all land here
		default: begin
			if (b == ESCAPE_BYTE) begin
				blk_len           = '0;
				blk_pos           = '0;
				mode              = MODE_BIN;
				r.in_binary_block = 1'b1;
			end else if (eol) begin
				if (mode == MODE_EOL) begin
					r.action = ACT_SKIP;
				end else begin
					r.action = ACT_LINE;
					mode     = MODE_EOL;
				end
			end else begin
				mode = MODE_TEXT;
			end
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cr_ends_line = 1'b1;
			mode         = MODE_TEXT;
			blk_len      = '0;
			blk_pos      = '0;
			results_seen = 0;
			verdict_q.delete();
			pending <= 0;
		end else begin
			// results come back in order: compare with the oldest expectation
			if (dout.valid && dout.ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch($sformatf("result %0d (byte %02h) with no request pending",
						results_seen, dout.out_byte));
				end else begin
					want = verdict_q.pop_front();
					if (dout.out_byte !== want.out_byte) begin
						report_mismatch($sformatf("result %0d out_byte %02h, expected %02h",
							results_seen, dout.out_byte, want.out_byte));
					end
					if (dout.action !== want.action) begin
						report_mismatch($sformatf("result %0d (byte %02h) action %0d, expected %s",
							results_seen, want.out_byte, dout.action, want.action.name()));
					end
					if (dout.in_binary_block !== want.in_binary_block) begin
						report_mismatch($sformatf(
							"result %0d (byte %02h) in_binary_block %b, expected %b",
							results_seen, want.out_byte, dout.in_binary_block,
							want.in_binary_block));
					end
				end
				results_seen++;
			end

			// register write; other addresses are ignored
			if (psel && penable && pwrite && pready && paddr == CR_EOL_ADDR) begin
				cr_ends_line = pwdata[0];
			end

			// new expectation goes to the tail
			if (din.valid && din.ready) begin
				verdict_q.insert(verdict_q.size(), classify_byte(din.in_byte));
			end
			pending <= verdict_q.size();
		end
	end

endmodule

FILE: test/text_line_binary_escape_parser_tb.sv
// Top of the line parser testbench: clock, reset, byte stream and register
// writes; the verdict comes from the failure count of tlbe_line_checker.
// Depends on tlbe_pkg, tlbe_ifs, the parser RTL and tlbe_line_checker.
`timescale 1ns / 100ps

module text_line_binary_escape_parser_tb;
	import tlbe_pkg::*;

	localparam int unsigned        SPARE_REG    = 1;
	localparam logic [PADDR_W-1:0] CR_EOL_ADDR  = PADDR_W'(4 * REG_CR_EOL);
	localparam logic [PADDR_W-1:0] SPARE_ADDR   = PADDR_W'(4 * SPARE_REG);
	localparam int unsigned        QUIET_LIMIT  = 2000;
	localparam int unsigned        PHASE_BYTES  = 120;
	localparam int unsigned        DRAIN_CYCLES = 8;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned quiet_cycles;
	int unsigned bytes_sent;

	// per phase: none, sender idle, receiver stall, both
	int unsigned phase_idle[4]  = '{0, 56, 0, 24};
	int unsigned phase_stall[4] = '{0, 0, 56, 24};

	tlbe_in_if  din_if ();
	tlbe_out_if dout_if ();

	text_line_binary_escape_parser DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.din     (din_if),
		.dout    (dout_if)
	);

	tlbe_line_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.din        (din_if),
		.dout       (dout_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		dout_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do begin
			b = 8'($urandom_range(255));
		end while (b == ESCAPE_BYTE || b == LF_BYTE || b == CR_BYTE);
		return b;
	endfunction

	// payload leans on the bytes that mean something outside a block
	function automatic logic [7:0] payload_byte();
		case ($urandom_range(7))
		0: return ESCAPE_BYTE;
		1: return LF_BYTE;
		2: return CR_BYTE;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// called and returns on a falling edge
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			din_if.valid <= 1'b0;
			@(negedge clk);
		end
		din_if.valid   <= 1'b1;
		din_if.in_byte <= b;
		do @(posedge clk); while (!din_if.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		int unsigned n;
		n = $urandom_range(8, 0);
		repeat (n) send_byte(text_byte());
		n = $urandom_range(3, 1);
		repeat (n) send_byte($urandom_range(1) ? LF_BYTE : CR_BYTE);
	endtask

	task automatic send_block(input logic [31:0] len);
		send_byte(ESCAPE_BYTE);
		for (int i = 3; i >= 0; i--) begin
			send_byte(len[8*i +: 8]);
		end
		repeat (len) send_byte(payload_byte());
	endtask

	task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every request has its result, then let the pipe settle
	task automatic drain();
		din_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		// CR counted as end-of-line: EOL runs, escapes from both modes, empty block
		logic [7:0]  intro[$]  = '{8'h41, 8'h00, 8'hFF, LF_BYTE, CR_BYTE, LF_BYTE, 8'h78,
			CR_BYTE, ESCAPE_BYTE, 8'h00, 8'h00, 8'h00, 8'h02, LF_BYTE, ESCAPE_BYTE,
			ESCAPE_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, LF_BYTE, 8'h7A};
		// newline only: CR is plain text, also right after a line ends
		logic [7:0]  cr_text[$] = '{CR_BYTE, LF_BYTE, CR_BYTE};
		int unsigned pick;
		logic [31:0] len;

		clk             = 1'b0;
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		din_if.valid    = 1'b0;
		din_if.in_byte  = '0;
		dout_if.ready   = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		quiet_cycles    = 0;
		bytes_sent      = 0;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(CR_EOL_ADDR, 32'd1);
		foreach (intro[i]) send_byte(intro[i]);
		drain();
		write_reg(CR_EOL_ADDR, 32'd0);
		// a write to an unmapped register must leave the setting alone
		write_reg(SPARE_ADDR, 32'd1);
		foreach (cr_text[i]) send_byte(cr_text[i]);

		for (int p = 0; p < 4; p++) begin
			drain();
			write_reg(CR_EOL_ADDR, 32'((p + 1) % 2));
			idle_pct   = phase_idle[p];
			stall_pct  = phase_stall[p];
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					send_line();
				end else if (pick < 80) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(48, 13) : $urandom_range(12, 0);
					send_block(len);
				end else begin
					// loose bytes, no escapes so no block opens on random length bytes
					repeat ($urandom_range(6, 1)) begin
						send_byte(($urandom_range(2) == 0) ?
							($urandom_range(1) ? LF_BYTE : CR_BYTE) : text_byte());
					end
				end
			end
		end

		// longest block length; the stream stops inside its payload
		send_byte(ESCAPE_BYTE);
		repeat (4) send_byte(8'hFF);
		repeat (8) send_byte(payload_byte());
		drain();

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: text_line_binary_escape_parser.f
hw/rtl/tlbe_pkg.sv
hw/rtl/tlbe_ifs.sv
hw/rtl/tlbe_cfg.sv
hw/rtl/tlbe_core.sv
hw/rtl/text_line_binary_escape_parser.sv
test/tlbe_line_checker.sv
test/text_line_binary_escape_parser_tb.sv
